@@ sv/bcpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types, constants and the binomial table of the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    localparam int T_W       = 17;   // unsigned Q1.16 parameter
    localparam int COORD_W   = 16;   // signed Q12.4 coordinate
    localparam int N_W       = 3;    // degree field
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int ACC_W     = 41;   // Q.20 accumulator
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;
    localparam int BINOM_W   = 5;
    localparam int TAB_N     = 7;

    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [CFG_AW-1:0] REG_DEGREE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_POINT0 = 3'd1;

    localparam logic [0:TAB_N-1][0:TAB_N-1][BINOM_W-1:0] BINOM_TAB = '{
        '{5'd1, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd1, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd2, 5'd1,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd3, 5'd3,  5'd1,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd4, 5'd6,  5'd4,  5'd1,  5'd0, 5'd0},
        '{5'd1, 5'd5, 5'd10, 5'd10, 5'd5,  5'd1, 5'd0},
        '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1}
    };

    // classified word handed from front to back
    typedef struct packed {
        logic [T_W-1:0] t;
        logic [T_W-1:0] u;
        logic [N_W-1:0] deg;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_res;

    function automatic logic [BINOM_W-1:0] bcpe_binom(
        input logic [N_W-1:0] n,
        input logic [N_W-1:0] k
    );
        logic [BINOM_W-1:0] v;
        v = '0;
        if ((n < N_W'(TAB_N)) && (k < N_W'(TAB_N))) begin
            v = BINOM_TAB[n][k];
        end
        return v;
    endfunction

    // round half up from Q.20 to Q.4, then saturate
    function automatic logic signed [COORD_W-1:0] bcpe_round(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] s;
        logic signed [COORD_W-1:0] r;
        b = a + ACC_W'(32768);
        s = b >>> 16;
        if (s > ACC_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (s < -ACC_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/bcpe_fifo.sv @@
// ----------------------------------------------------------------------------
// bcpe_fifo
// Small synchronous queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module bcpe_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [AW:0]      r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        if (wr_en) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_en) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ sv/bcpe_front.sv @@
// ----------------------------------------------------------------------------
// bcpe_front
// Input side: holds the degree register, clamps t and degree, forms 1-t.
// ----------------------------------------------------------------------------
module bcpe_front #(
    parameter int MAX_DEGREE = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bcpe_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [bcpe_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                         i_push,
    input  logic [bcpe_pkg::T_W-1:0]     i_t,
    input  logic                         i_q_full,
    output logic                         o_full,
    output logic                         o_wr,
    output bcpe_pkg::t_item              o_item
);
    import bcpe_pkg::*;

    logic [N_W-1:0] r_degree;
    logic [T_W-1:0] t_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
        end else if (i_cfg_we && (i_cfg_addr == REG_DEGREE)) begin
            r_degree <= i_cfg_data[N_W-1:0];
        end
    end

    always_comb begin
        t_c          = (i_t > ONE_Q16) ? ONE_Q16 : i_t;
        o_item.t     = t_c;
        o_item.u     = ONE_Q16 - t_c;
        o_item.deg   = (r_degree > N_W'(MAX_DEGREE)) ? N_W'(MAX_DEGREE) : r_degree;
    end

    assign o_full = i_q_full;
    assign o_wr   = i_push && !i_q_full;

endmodule

@@ sv/bcpe_back.sv @@
// ----------------------------------------------------------------------------
// bcpe_back
// Evaluation pipeline: powers of t and 1-t, Bernstein weights, products with
// the control points, adder tree and rounding. Issue is credit based so the
// pipeline never stalls.
// ----------------------------------------------------------------------------
module bcpe_back #(
    parameter int MAX_DEGREE = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bcpe_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [bcpe_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                         i_item_valid,
    input  bcpe_pkg::t_item              i_item,
    output logic                         o_item_take,
    input  logic                         i_res_pop,
    output logic                         o_res_valid,
    output bcpe_pkg::t_res               o_res
);
    import bcpe_pkg::*;

    localparam int NPTS   = MAX_DEGREE + 1;
    localparam int PSTG   = MAX_DEGREE - 1;
    localparam int IW     = (NPTS > 1) ? $clog2(NPTS) : 1;
    localparam int NPAIR  = (NPTS + 1) / 2;
    localparam int PROD_W = 2 * T_W - 1;
    localparam int W_W    = T_W + 4;
    localparam int TERM_W = W_W + 1 + COORD_W;
    localparam int CRW    = $clog2(OUT_DEPTH) + 1;

    typedef logic [NPTS-1:0][T_W-1:0] t_pow_vec;

    // control points
    logic [CFG_DW-1:0] r_pt [NPTS];

    for (genvar j = 0; j < NPTS; j++) begin : g_pt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pt[j] <= '0;
            end else if (i_cfg_we && (i_cfg_addr == REG_POINT0 + CFG_AW'(j))) begin
                r_pt[j] <= i_cfg_data;
            end
        end
    end

    // credits cover everything in flight plus the result queue
    logic [CRW-1:0] r_credit, n_credit;
    logic           issue;

    assign issue       = i_item_valid && (r_credit < CRW'(OUT_DEPTH));
    assign o_item_take = issue;

    always_comb begin
        n_credit = r_credit + CRW'(issue) - CRW'(i_res_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    // power stages
    t_pow_vec       r_tp  [PSTG+1];
    t_pow_vec       r_up  [PSTG+1];
    logic [N_W-1:0] r_deg [PSTG+1];
    logic           r_pv  [PSTG+1];
    t_pow_vec       n_tp0, n_up0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0;
        end else begin
            r_pv[0] <= issue;
        end
    end

    always_comb begin
        n_tp0    = '0;
        n_up0    = '0;
        n_tp0[0] = ONE_Q16;
        n_up0[0] = ONE_Q16;
        n_tp0[1] = i_item.t;
        n_up0[1] = i_item.u;
    end

    always_ff @(posedge i_clk) begin
        r_tp[0]  <= n_tp0;
        r_up[0]  <= n_up0;
        r_deg[0] <= i_item.deg;
    end

    for (genvar s = 1; s <= PSTG; s++) begin : g_pow
        localparam int K = s + 1;
        logic [2*T_W-1:0] tmul, umul;
        t_pow_vec         n_tp, n_up;

        assign tmul = r_tp[s-1][K-1] * r_tp[s-1][1];
        assign umul = r_up[s-1][K-1] * r_up[s-1][1];

        always_comb begin
            n_tp    = r_tp[s-1];
            n_up    = r_up[s-1];
            n_tp[K] = T_W'((tmul + (2*T_W)'(32768)) >> 16);
            n_up[K] = T_W'((umul + (2*T_W)'(32768)) >> 16);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[s] <= 1'b0;
            end else begin
                r_pv[s] <= r_pv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tp[s]  <= n_tp;
            r_up[s]  <= n_up;
            r_deg[s] <= r_deg[s-1];
        end
    end

    // u^(n-i) * t^i
    logic [PROD_W-1:0] r_prod [NPTS];
    logic [N_W-1:0]    r_deg_p;
    logic              r_v_p;

    for (genvar i = 0; i < NPTS; i++) begin : g_prod
        logic [IW-1:0]    ui;
        logic [2*T_W-1:0] mp;

        assign ui = IW'(r_deg[PSTG] - N_W'(i));
        assign mp = (N_W'(i) <= r_deg[PSTG]) ? r_up[PSTG][ui] * r_tp[PSTG][i] : '0;

        always_ff @(posedge i_clk) begin
            r_prod[i] <= PROD_W'(mp);
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg_p <= r_deg[PSTG];
    end

    // weights
    logic [W_W-1:0] r_w [NPTS];
    logic           r_v_w;

    for (genvar i = 0; i < NPTS; i++) begin : g_wgt
        logic [PROD_W-1:0]        rp;
        logic [T_W+BINOM_W-1:0]   wm;

        assign rp = r_prod[i] + PROD_W'(32768);
        assign wm = bcpe_binom(r_deg_p, N_W'(i)) * rp[PROD_W-1:16];

        always_ff @(posedge i_clk) begin
            r_w[i] <= W_W'(wm);
        end
    end

    // weight times control point
    logic signed [TERM_W-1:0] r_tx [NPTS];
    logic signed [TERM_W-1:0] r_ty [NPTS];
    logic                     r_v_t;

    for (genvar i = 0; i < NPTS; i++) begin : g_term
        logic signed [W_W:0]      ws;
        logic signed [TERM_W-1:0] mx, my;

        assign ws = $signed({1'b0, r_w[i]});
        assign mx = ws * $signed(r_pt[i][CFG_DW-1:COORD_W]);
        assign my = ws * $signed(r_pt[i][COORD_W-1:0]);

        always_ff @(posedge i_clk) begin
            r_tx[i] <= mx;
            r_ty[i] <= my;
        end
    end

    // pair sums
    logic signed [ACC_W-1:0] r_sx [NPAIR];
    logic signed [ACC_W-1:0] r_sy [NPAIR];
    logic                    r_v_s;

    for (genvar j = 0; j < NPAIR; j++) begin : g_pair
        if (2 * j + 1 < NPTS) begin : g_two
            always_ff @(posedge i_clk) begin
                r_sx[j] <= ACC_W'(r_tx[2*j]) + ACC_W'(r_tx[2*j+1]);
                r_sy[j] <= ACC_W'(r_ty[2*j]) + ACC_W'(r_ty[2*j+1]);
            end
        end else begin : g_one
            always_ff @(posedge i_clk) begin
                r_sx[j] <= ACC_W'(r_tx[2*j]);
                r_sy[j] <= ACC_W'(r_ty[2*j]);
            end
        end
    end

    // final sum
    logic signed [ACC_W-1:0] r_ax, r_ay;
    logic signed [ACC_W-1:0] sum_x, sum_y;
    logic                    r_v_a;

    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int j = 0; j < NPAIR; j++) begin
            sum_x = sum_x + r_sx[j];
            sum_y = sum_y + r_sy[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax <= sum_x;
        r_ay <= sum_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_p <= 1'b0;
            r_v_w <= 1'b0;
            r_v_t <= 1'b0;
            r_v_s <= 1'b0;
            r_v_a <= 1'b0;
        end else begin
            r_v_p <= r_pv[PSTG];
            r_v_w <= r_v_p;
            r_v_t <= r_v_w;
            r_v_s <= r_v_t;
            r_v_a <= r_v_s;
        end
    end

    assign o_res_valid = r_v_a;
    assign o_res.x     = bcpe_round(r_ax);
    assign o_res.y     = bcpe_round(r_ay);

endmodule

@@ sv/bezier_curve_point_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator_core: Bernstein-form Bezier point evaluator
// Path from the push to the word showing on the output: input stage,
// MAX_DEGREE - 1 power stages, product, weight, term and two sum stages,
// then the output queue write.
// Throughput one word per cycle while credits and queue space allow; reset clears queues, degree and points to 0.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator_core #(
    parameter int MAX_DEGREE = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bcpe_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [bcpe_pkg::CFG_DW-1:0]         i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [bcpe_pkg::T_W-1:0]            i_t,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [bcpe_pkg::COORD_W-1:0] o_x,
    output logic signed [bcpe_pkg::COORD_W-1:0] o_y
);
    import bcpe_pkg::*;

    t_item f_item, q_item;
    t_res  b_res, o_res;
    logic  f_wr, q_full, q_empty, take;
    logic  res_valid, res_pop;

    bcpe_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_t        (i_t),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_wr       (f_wr),
        .o_item     (f_item)
    );

    bcpe_fifo #(.WIDTH($bits(t_item)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_data  (f_item),
        .o_full  (q_full),
        .i_rd    (take),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    bcpe_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (!q_empty),
        .i_item       (q_item),
        .o_item_take  (take),
        .i_res_pop    (res_pop),
        .o_res_valid  (res_valid),
        .o_res        (b_res)
    );

    // credits in the back end keep this queue from overflowing
    bcpe_fifo #(.WIDTH($bits(t_res)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_data  (b_res),
        .o_full  (),
        .i_rd    (pop),
        .o_data  (o_res),
        .o_empty (empty)
    );

    assign res_pop = pop && !empty;
    assign o_x     = o_res.x;
    assign o_y     = o_res.y;

endmodule

@@ test/bezier_curve_point_evaluator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator_core_tb
// Loads a degree and seven control points, streams t words through the queue
// ports and checks every curve point against a fixed-point Bernstein
// predictor. Both sides idle at random; points include the coordinate extremes.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator_core_tb;
    import bcpe_pkg::*;

    localparam int     MAX_DEG   = 6;
    localparam int     N_PTS     = 7;
    localparam int     LATENCY   = MAX_DEG + 7;
    localparam int     N_DIR     = 24;
    localparam int     N_RAND    = 1926;
    localparam int     PHASE_LEN = 60;
    localparam longint Q16_ONE   = 65536;

    localparam logic [CFG_DW-1:0] PT_ZERO = 32'h0000_0000;
    localparam logic [CFG_DW-1:0] PT_MAX  = 32'h7FFF_7FFF;
    localparam logic [CFG_DW-1:0] PT_MIN  = 32'h8000_8000;
    localparam logic [CFG_DW-1:0] PT_MIX  = 32'h7FFF_8000;
    localparam logic [CFG_DW-1:0] PT_A    = 32'h0100_FF00;
    localparam logic [CFG_DW-1:0] PT_B    = 32'hC350_1234;
    localparam logic [CFG_DW-1:0] PT_JUNK = 32'hDEAD_BEEF;

    localparam logic [T_W-1:0] T_ZERO = 17'h00000;
    localparam logic [T_W-1:0] T_HALF = 17'h08000;
    localparam logic [T_W-1:0] T_JUST = 17'h10001;
    localparam logic [T_W-1:0] T_TOP  = 17'h1FFFF;

    typedef struct {
        bit                load;
        logic [CFG_DW-1:0] deg_word;
        logic [CFG_DW-1:0] pts [N_PTS];
        logic [T_W-1:0]    tv;
        bit                typed;
        t_res              pt;
    } t_dir_row;

    logic                      i_clk;
    logic                      i_rst_n    = 1'b0;
    logic                      i_cfg_we   = 1'b0;
    logic [CFG_AW-1:0]         i_cfg_addr = '0;
    logic [CFG_DW-1:0]         i_cfg_data = '0;
    logic                      push       = 1'b0;
    logic                      full;
    logic [T_W-1:0]            i_t        = '0;
    logic                      empty;
    logic                      pop        = 1'b0;
    logic signed [COORD_W-1:0] o_x;
    logic signed [COORD_W-1:0] o_y;

    // shadow of the register file
    logic [N_W-1:0]    curve_degree = '0;
    logic [CFG_DW-1:0] ctrl_pt [N_PTS] = '{default: '0};

    t_res point_q [$];
    int   err_count = 0;
    bit   push_gaps = 1'b1;
    bit   pop_gaps  = 1'b1;

    t_dir_row dir_tab [N_DIR] = '{
        // after reset: degree 0, all points zero
        '{0, 32'd0, '{default: PT_ZERO}, T_ZERO, 1, '{16'h0000, 16'h0000}},
        '{0, 32'd0, '{default: PT_ZERO}, T_TOP,  1, '{16'h0000, 16'h0000}},
        // degree 0 gives point 0 for any t
        '{1, 32'd0, '{PT_MIX, PT_JUNK, PT_JUNK, PT_JUNK, PT_JUNK, PT_JUNK, PT_JUNK},
          T_HALF, 1, '{16'h7FFF, 16'h8000}},
        '{0, 32'd0, '{default: PT_ZERO}, T_TOP, 1, '{16'h7FFF, 16'h8000}},
        // straight line, ends and t above one
        '{1, 32'd1, '{PT_A, PT_MIX, PT_JUNK, PT_JUNK, PT_JUNK, PT_JUNK, PT_JUNK},
          T_ZERO, 1, '{16'h0100, 16'hFF00}},
        '{0, 32'd0, '{default: PT_ZERO}, ONE_Q16, 1, '{16'h7FFF, 16'h8000}},
        '{0, 32'd0, '{default: PT_ZERO}, T_JUST,  1, '{16'h7FFF, 16'h8000}},
        '{0, 32'd0, '{default: PT_ZERO}, T_TOP,   1, '{16'h7FFF, 16'h8000}},
        '{0, 32'd0, '{default: PT_ZERO}, T_HALF,    0, '{16'h0, 16'h0}},
        '{0, 32'd0, '{default: PT_ZERO}, 17'h00001, 0, '{16'h0, 16'h0}},
        '{0, 32'd0, '{default: PT_ZERO}, 17'h0FFFF, 0, '{16'h0, 16'h0}},
        // full degree at the coordinate extremes, saturation reachable
        '{1, 32'd6, '{default: PT_MAX}, T_HALF, 0, '{16'h0, 16'h0}},
        '{0, 32'd0, '{default: PT_ZERO}, 17'h05555, 0, '{16'h0, 16'h0}},
        '{1, 32'd6, '{default: PT_MIN}, T_HALF, 0, '{16'h0, 16'h0}},
        '{1, 32'd6, '{PT_MAX, PT_MIN, PT_MAX, PT_MIN, PT_MAX, PT_MIN, PT_MAX},
          17'h0AAAA, 0, '{16'h0, 16'h0}},
        // degree above the limit is clamped to the top degree
        '{1, 32'hFFFF_FFFF, '{PT_A, PT_JUNK, PT_JUNK, PT_JUNK, PT_JUNK, PT_JUNK, PT_MIX},
          ONE_Q16, 1, '{16'h7FFF, 16'h8000}},
        '{0, 32'd0, '{default: PT_ZERO}, T_ZERO, 1, '{16'h0100, 16'hFF00}},
        '{0, 32'd0, '{default: PT_ZERO}, T_HALF, 0, '{16'h0, 16'h0}},
        // points above the degree are ignored
        '{1, 32'd2, '{PT_A, PT_B, PT_MIX, PT_JUNK, PT_MAX, PT_MIN, PT_JUNK},
          ONE_Q16, 1, '{16'h7FFF, 16'h8000}},
        '{0, 32'd0, '{default: PT_ZERO}, T_HALF, 0, '{16'h0, 16'h0}},
        '{1, 32'd3, '{PT_MAX, PT_MIN, PT_A, PT_B, PT_JUNK, PT_JUNK, PT_JUNK},
          17'h04000, 0, '{16'h0, 16'h0}},
        '{1, 32'd4, '{PT_B, PT_A, PT_MIN, PT_MAX, PT_MIX, PT_JUNK, PT_JUNK},
          17'h0C000, 0, '{16'h0, 16'h0}},
        '{1, 32'd5, '{PT_MIX, PT_B, PT_MAX, PT_A, PT_MIN, PT_B, PT_JUNK},
          17'h06000, 0, '{16'h0, 16'h0}},
        '{0, 32'd0, '{default: PT_ZERO}, 17'h18000, 0, '{16'h0, 16'h0}}
    };

    bezier_curve_point_evaluator_core #(
        .MAX_DEGREE(MAX_DEG)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .push      (push),
        .full      (full),
        .i_t       (i_t),
        .empty     (empty),
        .pop       (pop),
        .o_x       (o_x),
        .o_y       (o_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Q.20 sum to Q12.4, round half up, then clamp
    function automatic logic signed [COORD_W-1:0] round_sat(input longint acc);
        longint r;
        r = (acc + 32768) >>> 16;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r[COORD_W-1:0];
    endfunction

    function automatic t_res bezier_point(input logic [T_W-1:0] tv);
        longint tq;
        longint uq;
        longint w;
        longint ax;
        longint ay;
        longint c;
        longint tpow [N_PTS];
        longint upow [N_PTS];
        int     n;
        t_res   r;
        tq = (tv > ONE_Q16) ? Q16_ONE : longint'(tv);
        uq = Q16_ONE - tq;
        tpow[0] = Q16_ONE;
        upow[0] = Q16_ONE;
        for (int k = 1; k < N_PTS; k++) begin
            tpow[k] = (tpow[k-1] * tq + 32768) >>> 16;
            upow[k] = (upow[k-1] * uq + 32768) >>> 16;
        end
        n  = (curve_degree > MAX_DEG) ? MAX_DEG : int'(curve_degree);
        ax = 0;
        ay = 0;
        c  = 1;
        for (int i = 0; i <= n; i++) begin
            w  = c * ((upow[n-i] * tpow[i] + 32768) >>> 16);
            ax += w * longint'($signed(ctrl_pt[i][31:16]));
            ay += w * longint'($signed(ctrl_pt[i][15:0]));
            c  = c * (n - i) / (i + 1);
        end
        r.x = round_sat(ax);
        r.y = round_sat(ay);
        return r;
    endfunction

    function automatic logic [CFG_DW-1:0] rand_point();
        case ($urandom_range(0, 5))
            0:       return PT_MAX;
            1:       return PT_MIN;
            2:       return PT_MIX;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [T_W-1:0] rand_t();
        case ($urandom_range(0, 9))
            0:       return T_ZERO;
            1:       return ONE_Q16;
            2:       return T_W'($urandom_range(65537, 131071));
            default: return T_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("%0t: %s", $time, what);
    endtask

    task automatic push_t(input logic [T_W-1:0] tv, input bit typed, input t_res typed_pt);
        int gap;
        gap = push_gaps ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_t  <= tv;
        do @(posedge i_clk); while (full);
        point_q = {point_q, (typed ? typed_pt : bezier_point(tv))};
    endtask

    // stop pushing, let every word come out, then let the pipe settle
    task automatic drain();
        push <= 1'b0;
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic load_curve(input logic [CFG_DW-1:0] deg_word,
                              input logic [CFG_DW-1:0] pts [N_PTS]);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_DEGREE;
        i_cfg_data <= deg_word;
        @(posedge i_clk);
        curve_degree = deg_word[N_W-1:0];
        for (int i = 0; i < N_PTS; i++) begin
            i_cfg_addr <= REG_POINT0 + CFG_AW'(i);
            i_cfg_data <= pts[i];
            @(posedge i_clk);
            ctrl_pt[i] = pts[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stim
        logic [CFG_DW-1:0] pts [N_PTS];
        logic [CFG_DW-1:0] deg_word;
        int                sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].load) begin
                drain();
                load_curve(dir_tab[r].deg_word, dir_tab[r].pts);
            end
            push_t(dir_tab[r].tv, dir_tab[r].typed, dir_tab[r].pt);
        end

        sent = 0;
        while (sent < N_RAND) begin
            drain();
            deg_word      = $urandom();
            deg_word[2:0] = N_W'($urandom_range(0, 7));
            foreach (pts[i]) pts[i] = rand_point();
            load_curve(deg_word, pts);
            // some phases run with no gaps on one or both sides
            push_gaps = ($urandom_range(0, 3) != 0);
            pop_gaps  = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_LEN && sent < N_RAND; k++) begin
                push_t(rand_t(), 1'b0, '0);
                sent++;
            end
        end

        drain();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : pop_side
        int   gap;
        t_res want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = pop_gaps ? $urandom_range(0, 5) : 0;
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (point_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word x %0d y %0d", o_x, o_y));
            end else begin
                want = point_q.pop_front();
                if (o_x !== want.x) begin
                    report_mismatch($sformatf("x got %0d expected %0d", o_x, want.x));
                end
                if (o_y !== want.y) begin
                    report_mismatch($sformatf("y got %0d expected %0d", o_y, want.y));
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
